FILE: sv/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// lrukv_pkg
// shared widths, codes and reset values for the lru key-value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lrukv_pkg;

    localparam int DATA_W          = 32;
    localparam int CAP_W           = 5;
    localparam int MAX_ENTRIES_DEF = 16;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic              OP_GET     = 1'b0;
    localparam logic              OP_SET     = 1'b1;
    localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

endpackage

`default_nettype wire

FILE: sv/lrukv_store.sv
// ----------------------------------------------------------------------------
// lrukv_store
// key and value memories, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lrukv_store #(
    parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF
) (
    input  wire                                                aclk,
    input  wire  [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] rd_addr,
    output logic [lrukv_pkg::DATA_W-1:0]                       rd_key,
    output logic [lrukv_pkg::DATA_W-1:0]                       rd_value,
    input  wire                                                wr_en,
    input  wire  [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] wr_addr,
    input  wire  [lrukv_pkg::DATA_W-1:0]                       wr_key,
    input  wire  [lrukv_pkg::DATA_W-1:0]                       wr_value
);

    logic [lrukv_pkg::DATA_W-1:0] key_mem   [MAX_ENTRIES];
    logic [lrukv_pkg::DATA_W-1:0] value_mem [MAX_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr]   <= wr_key;
            value_mem[wr_addr] <= wr_value;
        end
        rd_key   <= key_mem[rd_addr];
        rd_value <= value_mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: sv/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value cache with least-recently-used replacement
//
//   channel   direction  tdata                       tuser
//   s_        in         key [31:0], value [63:32]   opcode [0]
//   m_        out        read_value [31:0]           hit [0]
//   cfg_      in         capacity_in_use [4:0]       -
//
// a get steps through accept, a key scan over every entry through the
// single memory read port, a drain of the read, a rank update, and a load
// of the result register
// a set takes the same steps but the result load, its last step is the write-back
// a get waits in the last step while the previous result is not yet taken
// reset empties the cache through the valid bits, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [2*lrukv_pkg::DATA_W-1:0]     s_tdata,   // key, value
    input  wire  [0:0]                         s_tuser,   // opcode
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [lrukv_pkg::DATA_W-1:0]       m_tdata,   // read_value
    output logic [0:0]                         m_tuser,   // hit
    input  wire                                cfg_wr_en,
    input  wire  [lrukv_pkg::CAP_W-1:0]        cfg_wr_data
);

    localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RW    = IW;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CW    = (CNT_W > lrukv_pkg::CAP_W) ? CNT_W : lrukv_pkg::CAP_W;
    localparam int DW    = lrukv_pkg::DATA_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_RESP   = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [lrukv_pkg::CAP_W-1:0] capacity_reg, capacity_next;
    logic [CNT_W-1:0]            occ_reg, occ_next;
    logic                        valid_reg [MAX_ENTRIES];
    logic                        valid_next [MAX_ENTRIES];
    logic [RW-1:0]               rank_reg [MAX_ENTRIES];
    logic [RW-1:0]               rank_next [MAX_ENTRIES];
    logic                        evict_vec [MAX_ENTRIES];

    logic                        op_reg, op_next;
    logic [DW-1:0]               key_reg, key_next;
    logic [DW-1:0]               val_reg, val_next;
    logic                        evict_reg, evict_next;
    logic [CNT_W-1:0]            cap_reg, cap_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic                        chk_reg, chk_next;
    logic [IW-1:0]               chk_idx_reg;
    logic                        found_reg, found_next;
    logic [IW-1:0]               hit_idx_reg, hit_idx_next;
    logic [RW-1:0]               hit_rank_reg, hit_rank_next;
    logic [DW-1:0]               hit_val_reg, hit_val_next;
    logic                        free_found_reg, free_found_next;
    logic [IW-1:0]               free_idx_reg, free_idx_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic                        m_hit_reg, m_hit_next;
    logic [DW-1:0]               m_data_reg, m_data_next;

    logic [DW-1:0]               rd_key, rd_value;
    logic                        wr_en;
    logic [IW-1:0]               wr_addr;
    logic [CW-1:0]               cap_wide;
    logic [CNT_W-1:0]            cap_eff;
    logic [RW-1:0]               thr;
    logic                        s_accept;
    logic                        match;
    logic                        free_here;

    lrukv_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .aclk     (aclk),
        .rd_addr  (idx_reg),
        .rd_key   (rd_key),
        .rd_value (rd_value),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (key_reg),
        .wr_value (val_reg)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_hit_reg;

    assign thr       = RW'(cap_reg - 1'b1);
    assign match     = chk_reg && valid_reg[chk_idx_reg] && (rd_key == key_reg);
    assign free_here = chk_reg && (!valid_reg[chk_idx_reg] ||
                       (evict_reg && (rank_reg[chk_idx_reg] >= thr)));

    assign wr_en   = (state_reg == ST_UPDATE) && (op_reg == lrukv_pkg::OP_SET);
    assign wr_addr = found_reg ? hit_idx_reg : free_idx_reg;

    // effective capacity, clamped to 1 .. MAX_ENTRIES
    always_comb begin
        cap_wide = CW'(capacity_reg);
        if (cap_wide == '0) begin
            cap_wide = CW'(1);
        end
        if (cap_wide > CW'(MAX_ENTRIES)) begin
            cap_wide = CW'(MAX_ENTRIES);
        end
        cap_eff = cap_wide[CNT_W-1:0];
    end

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            evict_vec[i] = evict_reg && valid_reg[i] && (rank_reg[i] >= thr);
        end
    end

    always_comb begin
        state_next      = state_reg;
        capacity_next   = cfg_wr_en ? cfg_wr_data : capacity_reg;
        occ_next        = occ_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        evict_next      = evict_reg;
        cap_next        = cap_reg;
        idx_next        = idx_reg;
        chk_next        = 1'b0;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        hit_val_next    = hit_val_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_hit_next      = m_hit_reg;
        m_data_next     = m_data_reg;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            valid_next[i] = valid_reg[i];
            rank_next[i]  = rank_reg[i];
        end

        // compare stage behind the registered read
        if (match && !found_reg) begin
            found_next    = 1'b1;
            hit_idx_next  = chk_idx_reg;
            hit_rank_next = rank_reg[chk_idx_reg];
            hit_val_next  = rd_value;
        end
        if (free_here && !free_found_reg) begin
            free_found_next = 1'b1;
            free_idx_next   = chk_idx_reg;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    op_next         = s_tuser[0];
                    key_next        = s_tdata[DW-1:0];
                    val_next        = s_tdata[2*DW-1:DW];
                    cap_next        = cap_eff;
                    evict_next      = (occ_reg >= cap_eff);
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                chk_next = 1'b1;
                if (idx_reg == IW'(MAX_ENTRIES - 1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (op_reg == lrukv_pkg::OP_GET) begin
                    if (found_reg) begin
                        for (int i = 0; i < MAX_ENTRIES; i++) begin
                            if (valid_reg[i] && (IW'(i) != hit_idx_reg) &&
                                (rank_reg[i] < hit_rank_reg)) begin
                                rank_next[i] = rank_reg[i] + 1'b1;
                            end
                        end
                        rank_next[hit_idx_reg] = '0;
                    end
                    state_next = ST_RESP;
                end else begin
                    if (!found_reg) begin
                        for (int i = 0; i < MAX_ENTRIES; i++) begin
                            if (evict_vec[i]) begin
                                valid_next[i] = 1'b0;
                                rank_next[i]  = '0;
                            end else if (valid_reg[i]) begin
                                rank_next[i] = rank_reg[i] + 1'b1;
                            end
                        end
                        valid_next[free_idx_reg] = 1'b1;
                        rank_next[free_idx_reg]  = '0;
                        occ_next = (evict_reg ? (cap_reg - 1'b1) : occ_reg) + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_hit_next    = found_reg;
                    m_data_next   = found_reg ? hit_val_reg : lrukv_pkg::MISS_VALUE;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            capacity_reg   <= lrukv_pkg::CAP_RESET;
            occ_reg        <= '0;
            chk_reg        <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end else begin
            state_reg      <= state_next;
            capacity_reg   <= capacity_next;
            occ_reg        <= occ_next;
            chk_reg        <= chk_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            m_tvalid_reg   <= m_tvalid_next;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                valid_reg[i] <= valid_next[i];
                rank_reg[i]  <= rank_next[i];
            end
        end
    end

    // item payload and scan results
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        evict_reg    <= evict_next;
        cap_reg      <= cap_next;
        idx_reg      <= idx_next;
        chk_idx_reg  <= idx_reg;
        hit_idx_reg  <= hit_idx_next;
        hit_rank_reg <= hit_rank_next;
        hit_val_reg  <= hit_val_next;
        free_idx_reg <= free_idx_next;
        m_hit_reg    <= m_hit_next;
        m_data_reg   <= m_data_next;
    end

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the lru key-value cache: a directed table of get
// and set items, then random phases over several capacities, each item
// predicted by a local copy of the cache and every result compared in order
// ----------------------------------------------------------------------------

module tb;

    localparam int NSLOT      = lrukv_pkg::MAX_ENTRIES_DEF;
    localparam int STALL_MAX  = 2000;
    localparam int DIR_N      = 16;
    localparam int PHASES     = 9;
    localparam int PHASE_LEN  = 193;
    localparam int POOL_N     = 24;

    typedef struct packed {
        logic                         hit;
        logic [lrukv_pkg::DATA_W-1:0] read_value;
    } lookup_t;

    typedef struct {
        logic                         op;
        logic [lrukv_pkg::DATA_W-1:0] key;
        logic [lrukv_pkg::DATA_W-1:0] value;
        bit                           typed;
        logic                         hit;
        logic [lrukv_pkg::DATA_W-1:0] read_value;
    } dir_row_t;

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [2*lrukv_pkg::DATA_W-1:0] s_tdata     = '0;
    logic [0:0]                     s_tuser     = '0;
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [lrukv_pkg::DATA_W-1:0]   m_tdata;
    logic [0:0]                     m_tuser;
    logic                           cfg_wr_en   = 1'b0;
    logic [lrukv_pkg::CAP_W-1:0]    cfg_wr_data = '0;

    // local copy of the cache
    logic [lrukv_pkg::DATA_W-1:0] slot_key   [NSLOT];
    logic [lrukv_pkg::DATA_W-1:0] slot_value [NSLOT];
    bit                           slot_valid [NSLOT];
    int unsigned                  slot_age   [NSLOT];
    int unsigned                  fill_count;
    logic [lrukv_pkg::CAP_W-1:0]  capacity;

    lookup_t     pending_lookups [$];
    int unsigned items_in;
    int unsigned quiet_cycles;
    int unsigned fault_count;
    int          tx_idle;
    int          rx_idle;

    logic [lrukv_pkg::DATA_W-1:0] key_pool [POOL_N];

    // directed items, all at reset capacity 16 on an empty cache
    dir_row_t dir_tab [DIR_N] = '{
        '{lrukv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, lrukv_pkg::MISS_VALUE},
        '{lrukv_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, lrukv_pkg::MISS_VALUE},
        '{lrukv_pkg::OP_SET, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{lrukv_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{lrukv_pkg::OP_SET, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{lrukv_pkg::OP_SET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{lrukv_pkg::OP_SET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{lrukv_pkg::OP_GET, 32'h8000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h8000_0000},
        '{lrukv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{lrukv_pkg::OP_SET, 32'h0000_0000, 32'h1234_5678, 1'b0, 1'b0, 32'h0},
        '{lrukv_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h1234_5678},
        '{lrukv_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{lrukv_pkg::OP_GET, 32'h0000_0005, 32'hFFFF_FFFF, 1'b1, 1'b0, lrukv_pkg::MISS_VALUE},
        '{lrukv_pkg::OP_SET, 32'h0000_0005, 32'hA5A5_5A5A, 1'b0, 1'b0, 32'h0},
        '{lrukv_pkg::OP_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{lrukv_pkg::OP_GET, 32'h0000_0004, 32'h0000_0000, 1'b1, 1'b0, lrukv_pkg::MISS_VALUE}
    };

    logic [lrukv_pkg::CAP_W-1:0] cap_plan [PHASES] = '{
        5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd16, 5'd2, 5'd8, 5'd16
    };

    lru_key_value_cache dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // applies one item to the local cache, returns the lookup a get gives
    function automatic bit cache_step(input logic op,
                                      input logic [lrukv_pkg::DATA_W-1:0] k,
                                      input logic [lrukv_pkg::DATA_W-1:0] v,
                                      output lookup_t res);
        int          i;
        int          slot;
        int          victim;
        int unsigned worst;
        int unsigned prior;
        int unsigned limit;
        slot = -1;
        res  = '{hit: 1'b0, read_value: lrukv_pkg::MISS_VALUE};
        for (i = 0; i < NSLOT; i++) begin
            if (slot < 0 && slot_valid[i] && slot_key[i] == k)
                slot = i;
        end
        if (op == lrukv_pkg::OP_GET) begin
            if (slot >= 0) begin
                prior = slot_age[slot];
                for (i = 0; i < NSLOT; i++) begin
                    if (slot_valid[i] && i != slot && slot_age[i] < prior)
                        slot_age[i]++;
                end
                slot_age[slot] = 0;
                res = '{hit: 1'b1, read_value: slot_value[slot]};
            end
            return 1'b1;
        end
        if (slot >= 0) begin
            slot_value[slot] = v;
            return 1'b0;
        end
        limit = (capacity == 0) ? 1 : (capacity > NSLOT) ? NSLOT : capacity;
        // evict oldest until there is room, covers a lowered capacity too
        while (fill_count >= limit && fill_count > 0) begin
            victim = -1;
            worst  = 0;
            for (i = 0; i < NSLOT; i++) begin
                if (slot_valid[i] && (victim < 0 || slot_age[i] >= worst)) begin
                    victim = i;
                    worst  = slot_age[i];
                end
            end
            slot_valid[victim] = 1'b0;
            slot_age[victim]   = 0;
            fill_count--;
        end
        for (i = NSLOT - 1; i >= 0; i--) begin
            if (!slot_valid[i])
                slot = i;
        end
        for (i = 0; i < NSLOT; i++) begin
            if (slot_valid[i])
                slot_age[i]++;
        end
        slot_key[slot]   = k;
        slot_value[slot] = v;
        slot_valid[slot] = 1'b1;
        slot_age[slot]   = 0;
        fill_count++;
        return 1'b0;
    endfunction

    always @(posedge aclk) begin
        m_tready <= (rx_idle == 0) || ($urandom_range(99) >= rx_idle);
    end

    // prediction on each accepted item, checking on each accepted result
    always @(posedge aclk) begin : scoreboard
        lookup_t res;
        lookup_t want;
        bit      gives;
        if (aresetn) begin
            if (cfg_wr_en)
                capacity = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                gives = cache_step(s_tuser[0], s_tdata[lrukv_pkg::DATA_W-1:0],
                                   s_tdata[2*lrukv_pkg::DATA_W-1:lrukv_pkg::DATA_W], res);
                if (items_in < DIR_N && dir_tab[items_in].typed)
                    res = '{hit: dir_tab[items_in].hit,
                            read_value: dir_tab[items_in].read_value};
                if (gives)
                    pending_lookups.push_back(res);
                items_in++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_lookups.size() == 0) begin
                    $error("unexpected result: hit %0b read_value %h", m_tuser[0], m_tdata);
                    fault_count++;
                end else begin
                    want = pending_lookups.pop_front();
                    if (m_tuser[0] !== want.hit) begin
                        $error("hit: expected %0b, got %0b", want.hit, m_tuser[0]);
                        fault_count++;
                    end
                    if (m_tdata !== want.read_value) begin
                        $error("read_value: expected %h, got %h", want.read_value, m_tdata);
                        fault_count++;
                    end
                end
            end
            // stall watchdog, generous against the slowest item and stall
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(input logic op, input logic [lrukv_pkg::DATA_W-1:0] k,
                             input logic [lrukv_pkg::DATA_W-1:0] v);
        if ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, k};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    // waits until the cache is idle and every result has been taken
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_lookups.size() != 0 || !s_tready || m_tvalid)
            @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [lrukv_pkg::CAP_W-1:0] cap);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int                           r;
        int                           ph;
        int                           n;
        logic                         op;
        logic [lrukv_pkg::DATA_W-1:0] k;
        logic [lrukv_pkg::DATA_W-1:0] v;
        for (r = 0; r < NSLOT; r++) begin
            slot_valid[r] = 1'b0;
            slot_age[r]   = 0;
        end
        fill_count   = 0;
        capacity     = lrukv_pkg::CAP_RESET;
        items_in     = 0;
        quiet_cycles = 0;
        fault_count  = 0;
        tx_idle      = 30;
        rx_idle      = 77;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < DIR_N; r++)
            send_item(dir_tab[r].op, dir_tab[r].key, dir_tab[r].value);

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES - 1)
                write_capacity(lrukv_pkg::CAP_W'($urandom_range(0, 31)));
            else
                write_capacity(cap_plan[ph]);
            tx_idle = (ph < 3) ? 30 : (ph < 6) ? 77 : 0;
            rx_idle = (ph < 3) ? 77 : (ph < 6) ? 30 : 0;
            // a small key set so that gets hit and inserts evict
            for (r = 0; r < POOL_N; r++)
                key_pool[r] = $urandom;
            key_pool[0] = 32'h0000_0000;
            key_pool[1] = 32'hFFFF_FFFF;
            key_pool[2] = 32'h8000_0000;
            key_pool[3] = 32'h7FFF_FFFF;
            for (n = 0; n < PHASE_LEN; n++) begin
                op = 1'($urandom_range(1));
                k  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_N - 1)]
                                               : $urandom;
                case ($urandom_range(9))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'hFFFF_FFFF;
                    2:       v = 32'h8000_0000;
                    3:       v = 32'h7FFF_FFFF;
                    default: v = $urandom;
                endcase
                send_item(op, k, v);
            end
        end

        wait_idle();
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/lrukv_pkg.sv
sv/lrukv_store.sv
sv/lru_key_value_cache.sv
test/tb.sv
